// File: sv/tspsi_pkg.sv
// shared types and constants of the transport stream psi parser
// no dependencies; used by tspsi_table, tspsi_parse and ts_packet_psi_parser
`default_nettype none

package tspsi_pkg;

    localparam int unsigned PidW     = 13;
    localparam int unsigned TblDepth = 1 << PidW;
    localparam int unsigned TblCntW  = PidW + 1;

    localparam logic [7:0] LastByte = 8'd187;
    localparam logic [8:0] BegFar   = 9'd511;

    typedef enum logic [1:0] {
        CLASS_OTHER = 2'd0,
        CLASS_PAT   = 2'd1,
        CLASS_PMT   = 2'd2
    } pkt_class_t;

    // one packet summary, as it leaves on the last byte
    typedef struct packed {
        logic [PidW-1:0] pcr_pid;
        logic [4:0]      section_version;
        logic [15:0]     section_id;
        pkt_class_t      packet_class;
        logic [7:0]      af_flags;
        logic [3:0]      continuity;
        logic [1:0]      adapt_control;
        logic [1:0]      scrambling;
        logic            priority_res;
        logic            unit_start;
        logic            error_ind;
        logic [PidW-1:0] pid;
    } result_t;

    // access to the program presence table
    typedef struct packed {
        logic            rd_en;
        logic [PidW-1:0] rd_addr;
        logic            wr_en;
        logic [PidW-1:0] wr_addr;
    } tbl_req_t;

endpackage

`default_nettype wire

// File: sv/tspsi_table.sv
// program presence table: one bit per pid, set by pat entries
// depends on tspsi_pkg; clears itself after reset, one entry per cycle
`default_nettype none

module tspsi_table (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire tspsi_pkg::tbl_req_t  req,
    output logic                      rd_data,
    output logic                      clearing
);

    logic                           present_mem [tspsi_pkg::TblDepth];
    logic [tspsi_pkg::TblCntW-1:0]  clr_cnt_reg;
    logic                           rd_data_reg;

    assign clearing = !clr_cnt_reg[tspsi_pkg::PidW];
    assign rd_data  = rd_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else if (clearing)
        begin
            clr_cnt_reg <= clr_cnt_reg + tspsi_pkg::TblCntW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (clearing)
        begin
            present_mem[clr_cnt_reg[tspsi_pkg::PidW-1:0]] <= 1'b0;
        end
        else if (req.wr_en)
        begin
            present_mem[req.wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.rd_en)
        begin
            rd_data_reg <= present_mem[req.rd_addr];
        end
    end

endmodule

`default_nettype wire

// File: sv/tspsi_parse.sv
// per-byte packet parser: header, adaptation flags, pointer field, pat/pmt fields
// depends on tspsi_pkg; drives the presence table lookups and entry writes
`default_nettype none

module tspsi_parse (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  item_valid,
    input  wire logic [7:0]            data_byte,
    input  wire logic                  packet_start,
    input  wire logic                  out_free,
    input  wire logic                  tbl_valid,
    output logic                       go,
    output logic                       is_last,
    output tspsi_pkg::tbl_req_t        tbl_req,
    output tspsi_pkg::result_t         result
);

    logic [7:0]                      byte_index_reg, byte_index_next;
    logic [23:0]                     header_word_reg, header_word_next;
    logic [8:0]                      payload_begin_reg, payload_begin_next;
    logic [8:0]                      section_begin_reg, section_begin_next;
    logic [11:0]                     section_len_reg, section_len_next;
    logic [20:0]                     section_fields_reg, section_fields_next;
    logic [4:0]                      entry_low_reg, entry_low_next;
    logic [7:0]                      flag_byte_reg, flag_byte_next;
    tspsi_pkg::pkt_class_t           pkt_class_reg, pkt_class_next;
    logic [tspsi_pkg::PidW-1:0]      pcr_value_reg, pcr_value_next;

    logic [7:0]  b;
    logic [7:0]  rel;
    logic [7:0]  entry_idx;
    logic [11:0] len_less;
    logic [9:0]  entry_count;
    logic [8:0]  sect_start;
    logic [8:0]  after_af;
    logic [tspsi_pkg::PidW-1:0] hdr_pid;

    always_comb
    begin
        b           = packet_start ? 8'd0 : byte_index_reg;
        is_last     = (b == tspsi_pkg::LastByte);
        go          = item_valid && (!is_last || out_free);
        rel         = b - section_begin_reg[7:0];
        entry_idx   = rel - 8'd8;
        len_less    = section_len_reg - 12'd9;
        entry_count = (section_len_reg >= 12'd9) ? len_less[11:2] : 10'd0;
        sect_start  = payload_begin_reg + {1'b0, data_byte} + 9'd1;
        after_af    = 9'd5 + {1'b0, data_byte};
        hdr_pid     = header_word_reg[12:0];

        header_word_next    = header_word_reg;
        payload_begin_next  = payload_begin_reg;
        section_begin_next  = section_begin_reg;
        section_len_next    = section_len_reg;
        section_fields_next = section_fields_reg;
        entry_low_next      = entry_low_reg;
        flag_byte_next      = flag_byte_reg;
        pkt_class_next      = pkt_class_reg;
        pcr_value_next      = pcr_value_reg;
        byte_index_next     = is_last ? 8'd0 : b + 8'd1;

        tbl_req         = '0;
        tbl_req.rd_addr = {header_word_reg[4:0], data_byte};
        tbl_req.wr_addr = {entry_low_reg, data_byte};
        // pid is complete with byte 2, so the presence lookup is issued on that byte
        tbl_req.rd_en   = go && (b == 8'd2);

        priority if (b == 8'd0)
        begin
            header_word_next    = '0;
            payload_begin_next  = '0;
            section_begin_next  = tspsi_pkg::BegFar;
            section_len_next    = '0;
            section_fields_next = '0;
            entry_low_next      = '0;
            flag_byte_next      = '0;
            pkt_class_next      = tspsi_pkg::CLASS_OTHER;
            pcr_value_next      = '0;
        end
        else if (b <= 8'd3)
        begin
            header_word_next = {header_word_reg[15:0], data_byte};
            if (b == 8'd3)
            begin
                if (data_byte[5:4] < 2'd2)
                begin
                    payload_begin_next = 9'd4;
                end
                if (hdr_pid == '0)
                begin
                    pkt_class_next = tspsi_pkg::CLASS_PAT;
                end
                else if (tbl_valid)
                begin
                    pkt_class_next = tspsi_pkg::CLASS_PMT;
                end
            end
        end
        else
        begin
            if (b == 8'd4 && header_word_reg[5])
            begin
                payload_begin_next = after_af;
            end
            if (b == 8'd5 && header_word_reg[5] && payload_begin_reg > 9'd5)
            begin
                flag_byte_next = data_byte;
            end
            if (pkt_class_reg != tspsi_pkg::CLASS_OTHER)
            begin
                priority if ({1'b0, b} == payload_begin_reg)
                begin
                    // pointer field
                    section_begin_next = sect_start;
                end
                else if ({1'b0, b} > section_begin_reg)
                begin
                    priority if (rel == 8'd1)
                    begin
                        section_len_next = {data_byte[3:0], 8'd0};
                    end
                    else if (rel == 8'd2)
                    begin
                        section_len_next[7:0] = data_byte;
                    end
                    else if (rel == 8'd3)
                    begin
                        section_fields_next[20:13] = data_byte;
                    end
                    else if (rel == 8'd4)
                    begin
                        section_fields_next[12:5] = data_byte;
                    end
                    else if (rel == 8'd5)
                    begin
                        section_fields_next[4:0] = data_byte[5:1];
                    end
                    else if (rel >= 8'd8 && pkt_class_reg == tspsi_pkg::CLASS_PMT)
                    begin
                        if (rel == 8'd8)
                        begin
                            pcr_value_next = {data_byte[4:0], 8'd0};
                        end
                        else if (rel == 8'd9)
                        begin
                            pcr_value_next[7:0] = data_byte;
                        end
                    end
                    else if (rel >= 8'd8 && pkt_class_reg == tspsi_pkg::CLASS_PAT)
                    begin
                        entry_low_next = data_byte[4:0];
                        // last byte of a program entry that lies inside the section
                        if (entry_idx[1:0] == 2'd3 && {4'd0, entry_idx[7:2]} < entry_count)
                        begin
                            tbl_req.wr_en = go;
                        end
                    end
                    else
                    begin
                        // section number bytes carry nothing we keep
                    end
                end
                else
                begin
                    // bytes up to and including the section's table id: adaptation field, bytes skipped by the pointer
                end
            end
        end

        result.pid             = header_word_reg[20:8];
        result.error_ind       = header_word_reg[23];
        result.unit_start      = header_word_reg[22];
        result.priority_res    = header_word_reg[21];
        result.scrambling      = header_word_reg[7:6];
        result.adapt_control   = header_word_reg[5:4];
        result.continuity      = header_word_reg[3:0];
        result.af_flags        = flag_byte_next;
        result.packet_class    = pkt_class_next;
        result.section_id      = (pkt_class_next != tspsi_pkg::CLASS_OTHER)
                                 ? section_fields_next[20:5] : 16'd0;
        result.section_version = (pkt_class_next != tspsi_pkg::CLASS_OTHER)
                                 ? section_fields_next[4:0] : 5'd0;
        result.pcr_pid         = (pkt_class_next == tspsi_pkg::CLASS_PMT)
                                 ? pcr_value_next : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_index_reg     <= '0;
            header_word_reg    <= '0;
            payload_begin_reg  <= '0;
            section_begin_reg  <= tspsi_pkg::BegFar;
            section_len_reg    <= '0;
            section_fields_reg <= '0;
            entry_low_reg      <= '0;
            flag_byte_reg      <= '0;
            pkt_class_reg      <= tspsi_pkg::CLASS_OTHER;
            pcr_value_reg      <= '0;
        end
        else if (go)
        begin
            byte_index_reg     <= byte_index_next;
            header_word_reg    <= header_word_next;
            payload_begin_reg  <= payload_begin_next;
            section_begin_reg  <= section_begin_next;
            section_len_reg    <= section_len_next;
            section_fields_reg <= section_fields_next;
            entry_low_reg      <= entry_low_next;
            flag_byte_reg      <= flag_byte_next;
            pkt_class_reg      <= pkt_class_next;
            pcr_value_reg      <= pcr_value_next;
        end
    end

endmodule

`default_nettype wire

// File: sv/ts_packet_psi_parser.sv
// top level of the transport stream psi parser: input register, parser, result register
// depends on tspsi_pkg, tspsi_table and tspsi_parse
`default_nettype none

// Takes a 188-byte transport stream packet one byte per transaction and gives one
// summary per packet, on its last byte: header fields, adaptation flag byte, and for
// PAT packets or PMT packets of a known program PID the section id and version, plus
// the PCR PID for PMT packets. A byte is accepted every clock unless a last byte waits
// for a full output register; the summary is held in that output register so input
// keeps flowing while it waits. Program presence is kept as one bit per PID in an
// 8192-entry memory, set by PAT entries and looked up once per packet when the PID is
// known. After reset that memory is cleared one entry per cycle, and no byte is
// accepted until the clear is done.
module ts_packet_psi_parser (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // data_byte[7:0]
    input  wire logic        s_tuser,   // packet_start
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // pid[12:0], error_ind[13], unit_start[14], priority_res[15], scrambling[17:16],
    // adapt_control[19:18], continuity[23:20], af_flags[31:24], section_id[47:32],
    // section_version[52:48], pcr_pid[65:53], zero[71:66]
    output logic [71:0]      m_tdata,
    output logic [1:0]       m_tuser    // packet_class
);

    logic                in_valid_reg;
    logic [7:0]          in_data_reg;
    logic                in_start_reg;
    logic                out_valid_reg;
    tspsi_pkg::result_t  out_data_reg;

    logic                go;
    logic                is_last;
    logic                out_free;
    logic                tbl_valid;
    logic                clearing;
    tspsi_pkg::tbl_req_t tbl_req;
    tspsi_pkg::result_t  result;

    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = !clearing && (!in_valid_reg || go);

    tspsi_table u_table (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (tbl_req),
        .rd_data  (tbl_valid),
        .clearing (clearing)
    );

    tspsi_parse u_parse (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (in_valid_reg),
        .data_byte    (in_data_reg),
        .packet_start (in_start_reg),
        .out_free     (out_free),
        .tbl_valid    (tbl_valid),
        .go           (go),
        .is_last      (is_last),
        .tbl_req      (tbl_req),
        .result       (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tvalid && s_tready)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (go)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_data_reg  <= s_tdata;
            in_start_reg <= s_tuser;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (go && is_last)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (go && is_last)
        begin
            out_data_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_data_reg.packet_class;
    assign m_tdata  = {6'd0,
                       out_data_reg.pcr_pid,
                       out_data_reg.section_version,
                       out_data_reg.section_id,
                       out_data_reg.af_flags,
                       out_data_reg.continuity,
                       out_data_reg.adapt_control,
                       out_data_reg.scrambling,
                       out_data_reg.priority_res,
                       out_data_reg.unit_start,
                       out_data_reg.error_ind,
                       out_data_reg.pid};

    // no transaction is taken while the presence memory is being cleared
    a_no_accept_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> !s_tready)
        else $error("input accepted during table clear");

    // a processed last byte always leaves a summary in the output register
    a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (go && is_last) |=> out_valid_reg)
        else $error("last byte processed without a result");

    // lookup and entry write never share a cycle
    a_tbl_one_access: assert property (@(posedge clk) disable iff (!rst_n)
        !(tbl_req.rd_en && tbl_req.wr_en))
        else $error("table read and write in one cycle");

endmodule

`default_nettype wire
